>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Holds the escape phase encoding, the command record that passes from the
// front end to the back end, and the character and UTF-8 constants they use.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Decoder phase within a string body.
   typedef enum logic [3:0] {
      PH_NORMAL  = 4'd0,
      PH_ESC     = 4'd1,
      PH_HEX0    = 4'd2,
      PH_HEX1    = 4'd3,
      PH_HEX2    = 4'd4,
      PH_HEX3    = 4'd5,
      PH_WAIT_BS = 4'd6,
      PH_WAIT_U  = 4'd7,
      PH_LOW0    = 4'd8,
      PH_LOW1    = 4'd9,
      PH_LOW2    = 4'd10,
      PH_LOW3    = 4'd11
   } phase_type;

   // What follows the optional UTF-8 sequence of a command.
   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_BYTE  = 2'd1,
      TAIL_ERROR = 2'd2,
      TAIL_END   = 2'd3
   } tail_type;

   // One queued command: an optional code point to encode, then a tail.
   typedef struct packed {
      logic        enc_valid;
      logic [20:0] code_point;
      tail_type    tail;
      logic [7:0]  tail_byte;
      logic        final_item;
   } cmd_type;

   // Result of decoding the character after a backslash.
   typedef struct packed {
      logic       is_u;
      tail_type   kind;
      logic [7:0] value;
   } esc_type;

   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6e;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   localparam logic [7:0] CTL_BS  = 8'h08;
   localparam logic [7:0] CTL_FF  = 8'h0c;
   localparam logic [7:0] CTL_LF  = 8'h0a;
   localparam logic [7:0] CTL_CR  = 8'h0d;
   localparam logic [7:0] CTL_TAB = 8'h09;

   // High surrogate prefix (top six bits of D800..DBFF).
   localparam logic [5:0]  HIGH_SURR_TOP = 6'b110110;
   localparam logic [20:0] SUPP_OFFSET   = 21'h10000;

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] UTF_CONT  = 8'h80;
   localparam logic [7:0] UTF_LEAD2 = 8'hc0;
   localparam logic [7:0] UTF_LEAD3 = 8'he0;
   localparam logic [7:0] UTF_LEAD4 = 8'hf0;

   // Hex digit value; bit 4 set when the byte is a valid digit.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Decode the character after a backslash.
   function automatic esc_type esc_decode(input logic [7:0] b);
      esc_type e;
      e.is_u  = 1'b0;
      e.kind  = TAIL_BYTE;
      e.value = b;
      priority case (b)
         CH_BACKSLASH, CH_QUOTE, CH_SLASH: e.value = b;
         CH_LOWER_B: e.value = CTL_BS;
         CH_LOWER_F: e.value = CTL_FF;
         CH_LOWER_N: e.value = CTL_LF;
         CH_LOWER_R: e.value = CTL_CR;
         CH_LOWER_T: e.value = CTL_TAB;
         CH_LOWER_U: begin
            e.is_u = 1'b1;
            e.kind = TAIL_NONE;
         end
         default: begin
            e.kind  = TAIL_ERROR;
            e.value = 8'd0;
         end
      endcase
      return e;
   endfunction

endpackage

>>> rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front: escape parser and classifier
// Tracks the escape phase of the string and turns each input byte into at
// most one command: an optional code point to encode plus a tail result.
// ----------------------------------------------------------------------------
module jsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             is_final,
   output logic             push,
   output jsu_pkg::cmd_type cmd
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [9:0]  pend_ff, pend_in;

   logic [4:0]       hv;
   logic [15:0]      acc_shift;
   jsu_pkg::esc_type esc;
   logic [20:0]      cp_high;
   logic [20:0]      cp_pair;
   jsu_pkg::phase_type mid_phase;

   // State registers advance only on an input transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsu_pkg::PH_NORMAL;
         acc_ff   <= 16'd0;
         pend_ff  <= 10'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
      end
   end

   assign hv        = jsu_pkg::hex_value(in_byte);
   assign acc_shift = {acc_ff[11:0], hv[3:0]};
   assign esc       = jsu_pkg::esc_decode(in_byte);
   assign cp_high   = {5'd0, jsu_pkg::HIGH_SURR_TOP, pend_ff};
   assign cp_pair   = jsu_pkg::SUPP_OFFSET + {1'b0, pend_ff, acc_shift[9:0]};

   // Next phase and command for the byte on the input.
   always_comb begin
      mid_phase      = phase_ff;
      acc_in         = acc_ff;
      pend_in        = pend_ff;
      cmd.enc_valid  = 1'b0;
      cmd.code_point = 21'd0;
      cmd.tail       = jsu_pkg::TAIL_NONE;
      cmd.tail_byte  = in_byte;
      cmd.final_item = is_final;

      unique case (phase_ff)
         jsu_pkg::PH_ESC: begin
            if (esc.is_u) begin
               mid_phase = jsu_pkg::PH_HEX0;
               acc_in    = 16'd0;
            end else begin
               mid_phase     = jsu_pkg::PH_NORMAL;
               cmd.tail      = esc.kind;
               cmd.tail_byte = esc.value;
            end
         end
         jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
            if (!hv[4]) begin
               mid_phase     = jsu_pkg::PH_NORMAL;
               cmd.tail      = jsu_pkg::TAIL_ERROR;
               cmd.tail_byte = 8'd0;
            end else begin
               acc_in = acc_shift;
               unique case (phase_ff)
                  jsu_pkg::PH_HEX0: mid_phase = jsu_pkg::PH_HEX1;
                  jsu_pkg::PH_HEX1: mid_phase = jsu_pkg::PH_HEX2;
                  jsu_pkg::PH_HEX2: mid_phase = jsu_pkg::PH_HEX3;
                  default: begin
                     if (acc_shift[15:10] == jsu_pkg::HIGH_SURR_TOP) begin
                        pend_in   = acc_shift[9:0];
                        mid_phase = jsu_pkg::PH_WAIT_BS;
                     end else begin
                        cmd.enc_valid  = 1'b1;
                        cmd.code_point = {5'd0, acc_shift};
                        mid_phase      = jsu_pkg::PH_NORMAL;
                     end
                  end
               endcase
            end
         end
         jsu_pkg::PH_WAIT_BS: begin
            if (in_byte == jsu_pkg::CH_BACKSLASH) begin
               mid_phase = jsu_pkg::PH_WAIT_U;
            end else begin
               cmd.enc_valid  = 1'b1;
               cmd.code_point = cp_high;
               cmd.tail       = jsu_pkg::TAIL_BYTE;
               mid_phase      = jsu_pkg::PH_NORMAL;
            end
         end
         jsu_pkg::PH_WAIT_U: begin
            if (in_byte == jsu_pkg::CH_LOWER_U) begin
               mid_phase = jsu_pkg::PH_LOW0;
               acc_in    = 16'd0;
            end else begin
               // Unpaired high surrogate, then an ordinary two-byte escape.
               cmd.enc_valid  = 1'b1;
               cmd.code_point = cp_high;
               cmd.tail       = esc.kind;
               cmd.tail_byte  = esc.value;
               mid_phase      = jsu_pkg::PH_NORMAL;
            end
         end
         jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2, jsu_pkg::PH_LOW3: begin
            if (!hv[4]) begin
               cmd.enc_valid  = 1'b1;
               cmd.code_point = cp_high;
               cmd.tail       = jsu_pkg::TAIL_ERROR;
               cmd.tail_byte  = 8'd0;
               mid_phase      = jsu_pkg::PH_NORMAL;
            end else begin
               acc_in = acc_shift;
               unique case (phase_ff)
                  jsu_pkg::PH_LOW0: mid_phase = jsu_pkg::PH_LOW1;
                  jsu_pkg::PH_LOW1: mid_phase = jsu_pkg::PH_LOW2;
                  jsu_pkg::PH_LOW2: mid_phase = jsu_pkg::PH_LOW3;
                  default: begin
                     cmd.enc_valid  = 1'b1;
                     cmd.code_point = cp_pair;
                     mid_phase      = jsu_pkg::PH_NORMAL;
                  end
               endcase
            end
         end
         default: begin
            // Normal text; unused phase codes behave the same.
            if (in_byte == jsu_pkg::CH_BACKSLASH) begin
               mid_phase = jsu_pkg::PH_ESC;
            end else begin
               mid_phase = jsu_pkg::PH_NORMAL;
               cmd.tail  = jsu_pkg::TAIL_BYTE;
            end
         end
      endcase

      phase_in = mid_phase;

      // End of string: flush whatever escape is still open, then reset.
      // The held surrogate may have been captured by this very byte.
      if (is_final) begin
         unique case (mid_phase)
            jsu_pkg::PH_NORMAL: begin
            end
            jsu_pkg::PH_WAIT_BS: begin
               cmd.enc_valid  = 1'b1;
               cmd.code_point = {5'd0, jsu_pkg::HIGH_SURR_TOP, pend_in};
            end
            jsu_pkg::PH_WAIT_U, jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1,
            jsu_pkg::PH_LOW2, jsu_pkg::PH_LOW3: begin
               cmd.enc_valid  = 1'b1;
               cmd.code_point = {5'd0, jsu_pkg::HIGH_SURR_TOP, pend_in};
               cmd.tail       = jsu_pkg::TAIL_ERROR;
               cmd.tail_byte  = 8'd0;
            end
            default: begin
               cmd.tail      = jsu_pkg::TAIL_ERROR;
               cmd.tail_byte = 8'd0;
            end
         endcase
         if (!cmd.enc_valid && cmd.tail == jsu_pkg::TAIL_NONE) begin
            cmd.tail      = jsu_pkg::TAIL_END;
            cmd.tail_byte = 8'd0;
         end
         phase_in = jsu_pkg::PH_NORMAL;
         acc_in   = 16'd0;
         pend_in  = 10'd0;
      end

      push = accept && (cmd.enc_valid || cmd.tail != jsu_pkg::TAIL_NONE);
   end

endmodule

>>> rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue: command queue between front end and back end
// A small circular buffer of commands with a fill count.
// ----------------------------------------------------------------------------
module jsu_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsu_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output jsu_pkg::cmd_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   jsu_pkg::cmd_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage takes no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back: UTF-8 encoder and result sequencer
// Expands the head command of the queue into one result per cycle while
// results are taken, and holds each result in an output register until taken.
// ----------------------------------------------------------------------------
module jsu_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  jsu_pkg::cmd_type head_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_byte,
   output logic             rsp_string_end,
   output logic             rsp_bad_escape,
   output logic             rsp_run_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       end_ff, end_in;
   logic       bad_ff, bad_in;
   logic       last_ff, last_in;

   logic [20:0] cp;
   logic [2:0]  enc_cnt;
   logic [2:0]  total;
   logic [2:0]  idx_ext;
   logic [7:0]  enc_byte [4];
   logic        in_enc;
   logic        last;
   logic        load;

   assign cp      = head_data.code_point;
   assign idx_ext = {1'b0, idx_ff};

   // UTF-8 length and bytes of the code point.
   always_comb begin
      enc_byte[0] = 8'd0;
      enc_byte[1] = 8'd0;
      enc_byte[2] = 8'd0;
      enc_byte[3] = 8'd0;
      if (cp[20:7] == 14'd0) begin
         enc_cnt     = 3'd1;
         enc_byte[0] = {1'b0, cp[6:0]};
      end else if (cp[20:11] == 10'd0) begin
         enc_cnt     = 3'd2;
         enc_byte[0] = jsu_pkg::UTF_LEAD2 | {3'd0, cp[10:6]};
         enc_byte[1] = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
      end else if (cp[20:16] == 5'd0) begin
         enc_cnt     = 3'd3;
         enc_byte[0] = jsu_pkg::UTF_LEAD3 | {4'd0, cp[15:12]};
         enc_byte[1] = jsu_pkg::UTF_CONT | {2'd0, cp[11:6]};
         enc_byte[2] = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
      end else begin
         enc_cnt     = 3'd4;
         enc_byte[0] = jsu_pkg::UTF_LEAD4 | {5'd0, cp[20:18]};
         enc_byte[1] = jsu_pkg::UTF_CONT | {2'd0, cp[17:12]};
         enc_byte[2] = jsu_pkg::UTF_CONT | {2'd0, cp[11:6]};
         enc_byte[3] = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
      end
   end

   // Select the result at the current position of the command.
   always_comb begin
      total = (head_data.enc_valid ? enc_cnt : 3'd0)
            + {2'd0, head_data.tail != jsu_pkg::TAIL_NONE};
      in_enc = head_data.enc_valid && (idx_ext < enc_cnt);
      last   = (idx_ext + 3'd1 == total);
      load   = head_valid && (!valid_ff || rsp_ready);
      pop    = load && last;

      byte_in = 8'd0;
      has_in  = 1'b0;
      bad_in  = 1'b0;
      if (in_enc) begin
         byte_in = enc_byte[idx_ff];
         has_in  = 1'b1;
      end else begin
         unique case (head_data.tail)
            jsu_pkg::TAIL_BYTE: begin
               byte_in = head_data.tail_byte;
               has_in  = 1'b1;
            end
            jsu_pkg::TAIL_ERROR: bad_in = 1'b1;
            default: begin
            end
         endcase
      end
      end_in  = head_data.final_item && last;
      last_in = last;

      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : idx_ff + 2'd1;
      end

      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         has_ff  <= has_in;
         end_ff  <= end_in;
         bad_ff  <= bad_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_has_byte   = has_ff;
   assign rsp_string_end = end_ff;
   assign rsp_bad_escape = bad_ff;
   assign rsp_run_last   = last_ff;

endmodule

>>> rtl/json_string_unescape_utf8.sv
// With the queue and output register empty, a byte's command is written into
// the queue, then its first result into the output register that offers it.
// Throughput: one input byte per cycle while the command queue has room, and
// one result per cycle while results are taken; a byte's command holds the
// encoder until all its results are loaded. QUEUE_DEPTH sets how far the
// input may run ahead of output. Reset, synchronous and active high, empties
// the queue, clears the output valid flag and sets the decoder to normal text.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string unescaper with UTF-8 output
// Front end parses escapes and queues commands; back end encodes UTF-8
// and delivers results through a registered output.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic       rsp_string_end,
   output logic       rsp_bad_escape,
   output logic       rsp_run_last
);

   logic             accept;
   logic             push;
   logic             pop;
   logic             full;
   logic             head_valid;
   jsu_pkg::cmd_type cmd;
   jsu_pkg::cmd_type head_data;

   // Input transfer whenever the queue can take a command.
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .is_final (req_is_final),
      .push     (push),
      .cmd      (cmd)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_data      (head_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_has_byte   (rsp_has_byte),
      .rsp_string_end (rsp_string_end),
      .rsp_bad_escape (rsp_bad_escape),
      .rsp_run_last   (rsp_run_last)
   );

endmodule

>>> rtl/jsu_checker.sv
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks for the JSON string unescaper
// Watches the top-level ports and flags results that break the format.
// ----------------------------------------------------------------------------
module jsu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_byte,
   input logic       rsp_string_end,
   input logic       rsp_bad_escape,
   input logic       rsp_run_last
);

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A result without data carries a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_byte) |-> (rsp_out_byte == 8'd0))
      else $error("nonzero byte on a result without data");

   // The end of a string is also the last result of its input byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_end) |-> rsp_run_last)
      else $error("string end without run end");

   // An error result never carries data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_escape) |-> !rsp_has_byte)
      else $error("error result carries data");

   // A stalled result stays offered with the same byte and run-last flag.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last)))
      else $error("stalled result changed");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);
